// File: rtl/core/ele_pkg.sv
// shared types and constants for the echo line editor
// no dependencies; imported by every module of the block
package ele_pkg;

  localparam int unsigned LINE_DEPTH = 256;
  localparam int unsigned CAP_W      = 9;
  localparam int unsigned CNT_W      = 8;

  localparam logic [7:0] BYTE_DEL = 8'd127;
  localparam logic [7:0] BYTE_CR  = 8'd13;
  localparam logic [7:0] BYTE_LF  = 8'd10;
  localparam logic [7:0] BYTE_BS  = 8'd8;
  localparam logic [7:0] BYTE_SP  = 8'd32;
  localparam logic [7:0] BYTE_NUL = 8'd0;

  // capacity saturates at the smaller of the store depth and 256
  localparam logic [CAP_W-1:0] CAP_MAX =
    (LINE_DEPTH > 256) ? CAP_W'(256) : CAP_W'(LINE_DEPTH);
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

  typedef enum logic [1:0] {
    CMD_CHAR = 2'd0,
    CMD_CR   = 2'd1,
    CMD_DEL  = 2'd2
  } cmd_kind_t;

  typedef logic [1:0] step_t;

  localparam step_t STEP_FIRST  = 2'd0;
  localparam step_t STEP_SECOND = 2'd1;
  localparam step_t STEP_THIRD  = 2'd2;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [7:0]       data;
    logic [CNT_W-1:0] count;
    logic             store;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// File: rtl/core/ele_front.sv
// front end: takes received bytes, classifies them and keeps the character count
// depends on ele_pkg; feeds commands into ele_queue
module ele_front import ele_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [CAP_W-1:0] cfg_wr_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_rx_byte,
  input  q_status_t        q_status,
  output logic             q_push,
  output cmd_t             q_cmd
);

  logic [CAP_W-1:0] cap_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [CAP_W-1:0] cap_eff;
  logic             is_del;
  logic             is_cr;
  logic             fits;
  logic             accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CAP_W'(1);
    end else if (cap_r > CAP_MAX) begin
      cap_eff = CAP_MAX;
    end else begin
      cap_eff = cap_r;
    end
  end

  assign is_del   = (in_rx_byte == BYTE_DEL);
  assign is_cr    = (in_rx_byte == BYTE_CR);
  assign fits     = ({1'b0, count_r} < (cap_eff - CAP_W'(1)));
  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;
  // delete on an empty line is taken but causes nothing
  assign q_push   = accept && !(is_del && (count_r == '0));

  always_comb begin
    q_cmd.data  = in_rx_byte;
    q_cmd.count = count_r;
    q_cmd.store = 1'b0;
    count_nxt   = count_r;
    if (is_del) begin
      q_cmd.kind = CMD_DEL;
      if (count_r != '0) begin
        count_nxt = count_r - CNT_W'(1);
      end
    end else if (is_cr) begin
      q_cmd.kind  = CMD_CR;
      q_cmd.store = 1'b1;
      count_nxt   = '0;
    end else begin
      q_cmd.kind  = CMD_CHAR;
      q_cmd.store = fits;
      if (fits) begin
        count_nxt = count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (accept) begin
      count_r <= count_nxt;
    end
  end

endmodule

// File: rtl/core/ele_queue.sv
// two-entry command queue between front and back end
// depends on ele_pkg
module ele_queue import ele_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  cmd_t      push_cmd,
  input  logic      pop,
  output cmd_t      head_cmd,
  output q_status_t status
);

  cmd_t       mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_push;
  logic       do_pop;

  assign status.full  = (cnt_r == 2'd2);
  assign status.empty = (cnt_r == 2'd0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head_cmd     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// File: rtl/core/ele_back.sv
// back end: expands each command into its echo items, one per cycle unless out_ready stalls
// depends on ele_pkg; drains ele_queue into the output register
module ele_back import ele_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             head_cmd,
  input  q_status_t        q_status,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_echo_valid,
  output logic [7:0]       out_echo_byte,
  output logic             out_store_valid,
  output logic [7:0]       out_store_index,
  output logic [7:0]       out_store_byte,
  output logic             out_line_done,
  output logic [CAP_W-1:0] out_line_length,
  output logic             out_last
);

  step_t            step_r;
  step_t            step_nxt;
  logic             valid_r;
  logic [7:0]       echo_r;
  logic             sv_r;
  logic [7:0]       sidx_r;
  logic [7:0]       sbyte_r;
  logic             done_r;
  logic [CAP_W-1:0] len_r;
  logic             last_r;

  logic             load;
  logic             emit;
  logic [7:0]       echo_nxt;
  logic             sv_nxt;
  logic [7:0]       sidx_nxt;
  logic [7:0]       sbyte_nxt;
  logic             done_nxt;
  logic [CAP_W-1:0] len_nxt;
  logic             last_nxt;

  assign load  = !valid_r || out_ready;
  assign emit  = load && !q_status.empty;
  assign q_pop = emit && last_nxt;

  always_comb begin
    echo_nxt  = head_cmd.data;
    sv_nxt    = 1'b0;
    sidx_nxt  = '0;
    sbyte_nxt = '0;
    done_nxt  = 1'b0;
    len_nxt   = '0;
    last_nxt  = 1'b1;
    case (head_cmd.kind)
      CMD_CHAR: begin
        sv_nxt    = head_cmd.store;
        sidx_nxt  = head_cmd.store ? head_cmd.count : '0;
        sbyte_nxt = head_cmd.store ? head_cmd.data : '0;
      end
      CMD_CR: begin
        if (step_r == STEP_FIRST) begin
          echo_nxt  = BYTE_CR;
          sv_nxt    = 1'b1;
          sidx_nxt  = head_cmd.count;
          sbyte_nxt = BYTE_NUL;
          last_nxt  = 1'b0;
        end else begin
          echo_nxt = BYTE_LF;
          done_nxt = 1'b1;
          len_nxt  = {1'b0, head_cmd.count} + CAP_W'(1);
        end
      end
      CMD_DEL: begin
        // backspace, space, backspace rubs out the last character
        echo_nxt = (step_r == STEP_SECOND) ? BYTE_SP : BYTE_BS;
        last_nxt = (step_r == STEP_THIRD);
      end
      default: begin
        echo_nxt = head_cmd.data;
      end
    endcase
  end

  always_comb begin
    step_nxt = step_r;
    if (emit) begin
      step_nxt = last_nxt ? STEP_FIRST : step_r + step_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= STEP_FIRST;
      valid_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      if (load) begin
        valid_r <= !q_status.empty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      echo_r  <= echo_nxt;
      sv_r    <= sv_nxt;
      sidx_r  <= sidx_nxt;
      sbyte_r <= sbyte_nxt;
      done_r  <= done_nxt;
      len_r   <= len_nxt;
      last_r  <= last_nxt;
    end
  end

  assign out_valid       = valid_r;
  assign out_echo_valid  = 1'b1;
  assign out_echo_byte   = echo_r;
  assign out_store_valid = sv_r;
  assign out_store_index = sidx_r;
  assign out_store_byte  = sbyte_r;
  assign out_line_done   = done_r;
  assign out_line_length = len_r;
  assign out_last        = last_r;

endmodule

// File: rtl/core/echo_line_editor.sv
// top level of the echo line editor: front end, command queue, back end
// depends on ele_pkg, ele_front, ele_queue, ele_back
//
//   port group   direction  handshake            payload
//   in_*         input      in_valid/in_ready    in_rx_byte
//   out_*        output     out_valid/out_ready  echo, store, line fields, last
//   cfg_*        input      cfg_wr_en            cfg_wr_data (line capacity)
//
// an ordinary byte gives one echo item, a carriage return two and a delete three;
// the back end emits one echo item per cycle unless out_ready stalls it
// the front end takes a new byte whenever the two-entry queue has room
// reset is synchronous; it clears the count, queue and output valid, and
// restores the capacity to 256
// a stall on out_ready holds the output register and backs up through the queue
module echo_line_editor import ele_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [CAP_W-1:0] cfg_wr_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_rx_byte,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_echo_valid,
  output logic [7:0]       out_echo_byte,
  output logic             out_store_valid,
  output logic [7:0]       out_store_index,
  output logic [7:0]       out_store_byte,
  output logic             out_line_done,
  output logic [CAP_W-1:0] out_line_length,
  output logic             out_last
);

  q_status_t q_status;
  logic      q_push;
  logic      q_pop;
  cmd_t      q_cmd;
  cmd_t      head_cmd;

  ele_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_rx_byte  (in_rx_byte),
    .q_status    (q_status),
    .q_push      (q_push),
    .q_cmd       (q_cmd)
  );

  ele_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .status   (q_status)
  );

  ele_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_cmd        (head_cmd),
    .q_status        (q_status),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_echo_valid  (out_echo_valid),
    .out_echo_byte   (out_echo_byte),
    .out_store_valid (out_store_valid),
    .out_store_index (out_store_index),
    .out_store_byte  (out_store_byte),
    .out_line_done   (out_line_done),
    .out_line_length (out_line_length),
    .out_last        (out_last)
  );

  // a finished line always closes its byte with a line feed
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_line_done |-> out_last && (out_echo_byte == BYTE_LF))
    else $error("line_done without final line feed");

  // the terminator write comes with the carriage return echo and is never last
  a_term_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_store_valid && (out_echo_byte == BYTE_CR) |->
      (out_store_byte == BYTE_NUL) && !out_last)
    else $error("bad terminator write");

  // the length is only reported with a finished line
  a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_line_done |-> (out_line_length == '0))
    else $error("line_length set outside a finished line");

  // a full queue must not accept a byte
  a_no_take_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_status.full |-> !in_ready)
    else $error("byte taken while queue full");

endmodule

// File: verif/echo_line_editor_tb.sv
// self-checking testbench for echo_line_editor: directed and random console bytes,
// with an in-order line editor predictor checking every echo item in order
// depends on ele_pkg and the echo_line_editor rtl
module echo_line_editor_tb;
  import ele_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 80;

  typedef struct packed {
    logic             echo_valid;
    logic [7:0]       echo_byte;
    logic             store_valid;
    logic [7:0]       store_index;
    logic [7:0]       store_byte;
    logic             line_done;
    logic [CAP_W-1:0] line_length;
    logic             last;
  } echo_result_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [CAP_W-1:0] cfg_wr_data;
  logic             in_valid;
  logic             in_ready;
  logic [7:0]       in_rx_byte;
  logic             out_valid;
  logic             out_ready;
  logic             out_echo_valid;
  logic [7:0]       out_echo_byte;
  logic             out_store_valid;
  logic [7:0]       out_store_index;
  logic [7:0]       out_store_byte;
  logic             out_line_done;
  logic [CAP_W-1:0] out_line_length;
  logic             out_last;

  // line editor predictor state
  logic [CNT_W-1:0] model_count    = '0;
  logic [CAP_W-1:0] model_capacity = CAP_RESET;
  echo_result_t     expected_echoes[$];
  echo_result_t     head_echo;

  int error_count     = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int cap_settings    = 0;
  int cycle_count     = 0;
  bit no_idle         = 1'b0;
  bit long_hold       = 1'b0;

  echo_line_editor dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_echo_valid  (out_echo_valid),
    .out_echo_byte   (out_echo_byte),
    .out_store_valid (out_store_valid),
    .out_store_index (out_store_index),
    .out_store_byte  (out_store_byte),
    .out_line_done   (out_line_done),
    .out_line_length (out_line_length),
    .out_last        (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d items still expected",
               $time, cycle_count, expected_echoes.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] random_char();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == BYTE_DEL || b == BYTE_CR);
    return b;
  endfunction

  function automatic void push_echo(input logic [7:0] echo, input logic sv,
                                    input logic [7:0] sidx, input logic [7:0] sbyte,
                                    input logic done, input logic [CAP_W-1:0] len,
                                    input logic lst);
    echo_result_t r;
    r.echo_valid  = 1'b1;
    r.echo_byte   = echo;
    r.store_valid = sv;
    r.store_index = sidx;
    r.store_byte  = sbyte;
    r.line_done   = done;
    r.line_length = len;
    r.last        = lst;
    expected_echoes.push_back(r);
  endfunction

  function automatic void predict_byte(input logic [7:0] b);
    int cap;
    cap = int'(model_capacity);
    if (cap < 1) cap = 1;
    if (cap > int'(CAP_MAX)) cap = int'(CAP_MAX);
    if (b == BYTE_DEL) begin
      // delete at an empty line produces nothing
      if (model_count != '0) begin
        push_echo(BYTE_BS, 1'b0, '0, '0, 1'b0, '0, 1'b0);
        push_echo(BYTE_SP, 1'b0, '0, '0, 1'b0, '0, 1'b0);
        push_echo(BYTE_BS, 1'b0, '0, '0, 1'b0, '0, 1'b1);
        model_count = model_count - CNT_W'(1);
      end
    end else if (b == BYTE_CR) begin
      push_echo(BYTE_CR, 1'b1, model_count, BYTE_NUL, 1'b0, '0, 1'b0);
      push_echo(BYTE_LF, 1'b0, '0, '0, 1'b1, {1'b0, model_count} + 9'd1, 1'b1);
      model_count = '0;
    end else if (int'(model_count) < cap - 1) begin
      push_echo(b, 1'b1, model_count, b, 1'b0, '0, 1'b1);
      model_count = model_count + CNT_W'(1);
    end else begin
      // line full: echoed, not stored
      push_echo(b, 1'b0, '0, '0, 1'b0, '0, 1'b1);
    end
  endfunction

  function automatic void check_field(input string name, input int unsigned exp_val,
                                      input int unsigned act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, act_val);
      error_count++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_echoes.size() == 0) begin
        $display("%0t: unexpected item, echo byte %0d, nothing expected",
                 $time, out_echo_byte);
        error_count++;
      end else begin
        head_echo = expected_echoes.pop_front();
        check_field("echo_valid",  head_echo.echo_valid,  out_echo_valid);
        check_field("echo_byte",   head_echo.echo_byte,   out_echo_byte);
        check_field("store_valid", head_echo.store_valid, out_store_valid);
        check_field("store_index", head_echo.store_index, out_store_index);
        check_field("store_byte",  head_echo.store_byte,  out_store_byte);
        check_field("line_done",   head_echo.line_done,   out_line_done);
        check_field("line_length", head_echo.line_length, out_line_length);
        check_field("last",        head_echo.last,        out_last);
      end
      results_checked++;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        long_hold = 1'b0;
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        stall_left = pick_gap();
        if (stall_left == 0) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          stall_left--;
        end
      end
    end
  end

  // valid stays high after acceptance so the next item can follow back to back;
  // any other time-consuming step must drop it first
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    predict_byte(b);
    items_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_echoes.size() != 0) @(posedge clk);
    // a delete at zero count may still be in flight
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    wait_idle();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    model_capacity = cap;
    cap_settings++;
  endtask

  task automatic test_default_line();
    send_byte(BYTE_DEL);
    send_byte(8'd0);
    send_byte(8'd255);
    send_byte(BYTE_LF);
    send_byte(BYTE_BS);
    send_byte(BYTE_DEL);
    send_byte(BYTE_CR);
  endtask

  task automatic test_delete();
    send_byte(8'h61);
    send_byte(8'h62);
    repeat (3) send_byte(BYTE_DEL);
    send_byte(BYTE_CR);
  endtask

  task automatic test_capacity_limits();
    // zero behaves as one: only the terminator fits
    set_capacity(9'd0);
    send_byte(8'h78);
    send_byte(BYTE_CR);
    set_capacity(9'd3);
    send_byte(8'd1);
    send_byte(8'd2);
    send_byte(8'd3);
    send_byte(BYTE_DEL);
    send_byte(8'd4);
    send_byte(BYTE_CR);
    set_capacity(9'd1);
    send_byte(8'h7a);
    send_byte(BYTE_CR);
  endtask

  task automatic test_backpressure();
    set_capacity(9'd8);
    no_idle   = 1'b1;
    long_hold = 1'b1;
    send_byte(8'h41);
    send_byte(BYTE_DEL);
    repeat (6) send_byte(random_char());
    send_byte(BYTE_DEL);
    send_byte(BYTE_CR);
    send_byte(BYTE_DEL);
    send_byte(BYTE_CR);
    no_idle = 1'b0;
    wait_idle();
  endtask

  // capacity above the store saturates
  task automatic test_long_line();
    set_capacity(9'd511);
    no_idle = 1'b1;
    repeat (20) send_byte(random_char());
    send_byte(BYTE_DEL);
    send_byte(random_char());
    send_byte(random_char());
    send_byte(BYTE_CR);
    no_idle = 1'b0;
  endtask

  task automatic test_random_lines(input logic [CAP_W-1:0] cap, input int n_items,
                                   input int max_len);
    int sent;
    int len;
    sent = 0;
    set_capacity(cap);
    while (sent < n_items) begin
      if ($urandom_range(0, 4) != 0) begin
        len = $urandom_range(0, max_len);
        repeat (len) begin
          send_byte(random_char());
          sent++;
          if ($urandom_range(0, 6) == 0) begin
            send_byte(BYTE_DEL);
            sent++;
          end
        end
        send_byte(BYTE_CR);
        sent++;
      end else begin
        send_byte(8'($urandom_range(0, 255)));
        sent++;
      end
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_valid    = 1'b0;
    in_rx_byte  = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    test_default_line();
    test_delete();
    test_capacity_limits();
    test_backpressure();
    test_long_line();

    test_random_lines(CAP_W'($urandom_range(2, 10)), 12, 8);
    test_random_lines(9'd0, 8, 3);
    no_idle = 1'b1;
    test_random_lines(CAP_W'($urandom_range(11, 40)), 12, 16);
    no_idle = 1'b0;
    test_random_lines(9'd300, 10, 12);

    wait_idle();
    $display("%0d items sent, %0d result items checked, %0d capacity writes",
             items_sent, results_checked, cap_settings);
    $display("covered capacities 0 to 511, full lines, deletes at empty lines, long stall");
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
